@@ hw/rtl/efa_pkg.sv @@
// Shared types and constants for the event frame accumulator.
`timescale 1ns / 1ps
package efa_pkg;

  localparam int KIND_W   = 2;
  localparam int COORD_W  = 7;
  localparam int POL_W    = 2;
  localparam int TIME_W   = 31;
  localparam int COUNT_W  = 16;
  localparam int MISS_W   = 8;
  localparam int PIXEL_W  = 8;
  localparam int INDEX_W  = 2;
  localparam int DATA_W   = 31;

  localparam int DEF_FRAME_WIDTH  = 128;
  localparam int DEF_FRAME_HEIGHT = 128;

  localparam logic [KIND_W-1:0] KIND_EVENT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MISS  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  localparam logic [INDEX_W-1:0] REG_FRAME_PERIOD = 2'd0;
  localparam logic [INDEX_W-1:0] REG_MAX_EVENTS   = 2'd1;
  localparam logic [INDEX_W-1:0] REG_MAX_MISSES   = 2'd2;

  localparam logic [TIME_W-1:0]  RST_FRAME_PERIOD = 31'd1000;
  localparam logic [COUNT_W-1:0] RST_MAX_EVENTS   = 16'd1000;
  localparam logic [MISS_W-1:0]  RST_MAX_MISSES   = 8'd3;

  typedef struct packed {
    logic               closed;
    logic               ok;
    logic [COUNT_W-1:0] events;
    logic [TIME_W-1:0]  next_start;
  } frame_res_t;

endpackage

@@ hw/rtl/efa_channels.sv @@
// Request and result channel interfaces.
`timescale 1ns / 1ps
interface efa_item_if;
  logic                             valid;
  logic                             ready;
  logic [efa_pkg::KIND_W-1:0]       kind;
  logic [efa_pkg::COORD_W-1:0]      x;
  logic [efa_pkg::COORD_W-1:0]      y;
  logic signed [efa_pkg::POL_W-1:0] polarity;
  logic [efa_pkg::TIME_W-1:0]       timestamp;

  modport source(output valid, kind, x, y, polarity, timestamp, input ready);
  modport sink(input valid, kind, x, y, polarity, timestamp, output ready);
endinterface

interface efa_result_if;
  logic                               valid;
  logic                               ready;
  logic                               frame_closed;
  logic                               frame_ok;
  logic [efa_pkg::COUNT_W-1:0]        events_in_frame;
  logic [efa_pkg::TIME_W-1:0]         next_start_time;
  logic signed [efa_pkg::PIXEL_W-1:0] pixel_value;

  modport source(output valid, frame_closed, frame_ok, events_in_frame, next_start_time,
                 pixel_value, input ready);
  modport sink(input valid, frame_closed, frame_ok, events_in_frame, next_start_time,
               pixel_value, output ready);
endinterface

@@ hw/rtl/event_frame_accumulator.sv @@
// Top level of the event frame accumulator.
// An accepted request passes the s1 register, then the output register, which holds its result.
// Throughput: one request per cycle unless the result channel stalls or the memory is clearing;
// the pixel memory does one read and one write per cycle. Reset: synchronous; afterwards
// a clearing pass zeroes the pixel memory with item.ready low.
// Config writes are taken at any time, including during the clearing pass.
`timescale 1ns / 1ps
module event_frame_accumulator #(
  parameter int FRAME_WIDTH  = efa_pkg::DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = efa_pkg::DEF_FRAME_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [efa_pkg::INDEX_W-1:0] wr_index,
  input  logic [efa_pkg::DATA_W-1:0]  wr_data,
  efa_item_if.sink                    item,
  efa_result_if.source                result
);
  import efa_pkg::*;

  frame_res_t res;
  logic       accept;

  efa_frame_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .accept    (accept),
    .kind      (item.kind),
    .timestamp (item.timestamp),
    .res       (res)
  );

  efa_pixel_pipe #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_pipe (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .res    (res),
    .accept (accept)
  );

endmodule

@@ hw/rtl/efa_frame_ctrl.sv @@
// Frame bookkeeping: config registers, open/close decisions, counters.
`timescale 1ns / 1ps
module efa_frame_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [efa_pkg::INDEX_W-1:0] wr_index,
  input  logic [efa_pkg::DATA_W-1:0]  wr_data,
  input  logic                        accept,
  input  logic [efa_pkg::KIND_W-1:0]  kind,
  input  logic [efa_pkg::TIME_W-1:0]  timestamp,
  output efa_pkg::frame_res_t         res
);
  import efa_pkg::*;

  logic [TIME_W-1:0]  frame_period;
  logic [COUNT_W-1:0] max_events;
  logic [MISS_W-1:0]  max_misses;

  logic               frame_open;
  logic [TIME_W-1:0]  start_time;
  logic [TIME_W:0]    end_time;
  logic [COUNT_W-1:0] event_count;
  logic [MISS_W-1:0]  miss_count;

  logic [TIME_W:0]    end_next;
  logic [TIME_W-1:0]  start_next;
  logic [COUNT_W-1:0] count_base;
  logic [COUNT_W-1:0] count_next;
  logic [MISS_W-1:0]  miss_base;
  logic [MISS_W-1:0]  miss_next;
  logic [MISS_W:0]    miss_inc;
  logic               closed;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_period <= RST_FRAME_PERIOD;
      max_events   <= RST_MAX_EVENTS;
      max_misses   <= RST_MAX_MISSES;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_FRAME_PERIOD: frame_period <= (wr_data == '0) ? RST_FRAME_PERIOD : wr_data;
        REG_MAX_EVENTS: begin
          max_events <= (wr_data[COUNT_W-1:0] == '0) ? RST_MAX_EVENTS : wr_data[COUNT_W-1:0];
        end
        REG_MAX_MISSES:   max_misses <= wr_data[MISS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    end_next   = frame_open ? end_time : ({1'b0, start_time} + {1'b0, frame_period});
    count_base = frame_open ? event_count : '0;
    miss_base  = frame_open ? miss_count : '0;
    miss_inc   = {1'b0, miss_base} + (MISS_W+1)'(1);
    count_next = count_base;
    miss_next  = miss_base;
    start_next = start_time;
    closed     = 1'b0;
    unique case (kind)
      KIND_EVENT: begin
        miss_next = '0;
        if (count_base != '1) count_next = count_base + COUNT_W'(1);
        if ({1'b0, timestamp} > end_next || count_next >= max_events) begin
          closed     = 1'b1;
          start_next = timestamp;
        end
      end
      KIND_MISS: begin
        miss_next = miss_inc[MISS_W] ? '1 : miss_inc[MISS_W-1:0];
        if (miss_inc > {1'b0, max_misses}) begin
          closed     = 1'b1;
          start_next = end_next[TIME_W] ? '1 : end_next[TIME_W-1:0];
        end
      end
      default: ;
    endcase
    res.closed     = closed;
    res.ok         = closed && (count_next != '0);
    res.events     = count_next;
    res.next_start = start_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open  <= 1'b0;
      start_time  <= '0;
      end_time    <= '0;
      event_count <= '0;
      miss_count  <= '0;
    end else if (accept) begin
      frame_open  <= !closed;
      start_time  <= start_next;
      end_time    <= end_next;
      event_count <= count_next;
      miss_count  <= miss_next;
    end
  end

endmodule

@@ hw/rtl/efa_pixel_pipe.sv @@
// Pixel memory with read-modify-write pipeline, clearing pass and output register.
`timescale 1ns / 1ps
module efa_pixel_pipe #(
  parameter int FRAME_WIDTH  = efa_pkg::DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = efa_pkg::DEF_FRAME_HEIGHT
) (
  input  logic                clk,
  input  logic                rst,
  efa_item_if.sink            item,
  efa_result_if.source        result,
  input  efa_pkg::frame_res_t res,
  output logic                accept
);
  import efa_pkg::*;

  localparam int PIX_COUNT = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W    = (PIX_COUNT > 1) ? $clog2(PIX_COUNT) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PIX_COUNT - 1);

  logic [PIXEL_W-1:0] mem [PIX_COUNT];

  logic               clr_busy;
  logic [ADDR_W-1:0]  clr_addr;

  logic [ADDR_W-1:0]  in_addr;
  logic               in_range;
  logic [PIXEL_W-1:0] rd_data;
  logic               fwd;
  logic [PIXEL_W-1:0] fwd_data;

  logic               s1_valid;
  logic               s1_event;
  logic               s1_read;
  logic               s1_in_range;
  logic [ADDR_W-1:0]  s1_addr;
  logic [PIXEL_W-1:0] s1_delta;
  frame_res_t         s1_res;
  logic               s1_move;
  logic               s1_write;
  logic [PIXEL_W-1:0] s1_cur;
  logic [PIXEL_W-1:0] s1_wdata;

  logic               o_valid;
  frame_res_t         o_res;
  logic [PIXEL_W-1:0] o_pixel;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [PIXEL_W-1:0] mem_wdata;

  assign in_range = (32'(item.x) < FRAME_WIDTH) && (32'(item.y) < FRAME_HEIGHT);
  assign in_addr  = ADDR_W'(item.x) * ADDR_W'(FRAME_HEIGHT) + ADDR_W'(item.y);

  assign s1_move    = s1_valid && (!o_valid || result.ready);
  assign item.ready = !clr_busy && (!s1_valid || s1_move);
  assign accept     = item.valid && item.ready;

  assign s1_cur   = fwd ? fwd_data : rd_data;
  assign s1_write = s1_move && s1_in_range && (s1_event || s1_read);
  assign s1_wdata = s1_event ? (s1_cur + s1_delta) : '0;

  assign mem_we    = clr_busy || s1_write;
  assign mem_waddr = clr_busy ? clr_addr : s1_addr;
  assign mem_wdata = clr_busy ? '0 : s1_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (accept) rd_data <= mem[in_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == LAST_ADDR) clr_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_event    <= (item.kind == KIND_EVENT);
      s1_read     <= (item.kind == KIND_READ);
      s1_in_range <= in_range;
      s1_addr     <= in_addr;
      s1_delta    <= {{(PIXEL_W-POL_W){item.polarity[POL_W-1]}}, item.polarity};
      s1_res      <= res;
      fwd         <= s1_write && (s1_addr == in_addr);
      fwd_data    <= s1_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_move) begin
      o_valid <= 1'b1;
    end else if (result.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      o_res   <= s1_res;
      o_pixel <= (s1_read && s1_in_range) ? s1_cur : '0;
    end
  end

  assign result.valid           = o_valid;
  assign result.frame_closed    = o_res.closed;
  assign result.frame_ok        = o_res.ok;
  assign result.events_in_frame = o_res.events;
  assign result.next_start_time = o_res.next_start;
  assign result.pixel_value     = o_pixel;

endmodule

@@ hw/rtl/efa_checker.sv @@
// Port-level assertions for the event frame accumulator, bound to the top level.
`timescale 1ns / 1ps
module efa_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                closed,
  input logic                                ok,
  input logic [efa_pkg::COUNT_W-1:0]         events,
  input logic [efa_pkg::TIME_W-1:0]          next_start,
  input logic signed [efa_pkg::PIXEL_W-1:0]  pixel
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(closed) && $stable(ok) &&
      $stable(events) && $stable(next_start) && $stable(pixel))
    else $error("result changed while stalled");

  a_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ok == (closed && events != '0)))
    else $error("frame_ok disagrees with close and count");

  a_clear: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("request taken before memory clear");

  a_no_result: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind event_frame_accumulator efa_checker u_efa_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (item.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .closed     (result.frame_closed),
  .ok         (result.frame_ok),
  .events     (result.events_in_frame),
  .next_start (result.next_start_time),
  .pixel      (result.pixel_value)
);
